/* rtl/mm4_pkg.sv */
// shared types and defaults for the 4x4 fixed-point matrix multiplier
package mm4_pkg;

    localparam int DIM_DEF       = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int WORD_BITS_DEF = 32;

    // index width that covers the largest supported dimension
    localparam int IDX_BITS = 3;

    typedef enum logic [1:0] {
        KIND_LOAD_LEFT  = 2'd0,
        KIND_LOAD_RIGHT = 2'd1,
        KIND_MUL        = 2'd2,
        KIND_MUL_KEEP   = 2'd3
    } kind_t;

    // travels down the cell chain alongside each product entry
    typedef struct packed {
        logic                valid;
        logic                keep;
        logic                last;
        logic [IDX_BITS-1:0] row;
        logic [IDX_BITS-1:0] col;
    } tag_t;

endpackage

/* rtl/matrix_multiply_4x4.sv */
// top level of the DIM x DIM signed fixed-point matrix multiplier
// A load transfer (kind 0 or 1) writes one entry of the left or right operand and the block
// takes the next transfer right after. A multiply transfer (kind 2 or 3) streams DIM*DIM
// entry requests, one per cycle while the output is not stalled, into a chain of DIM
// multiply-add cells; a request moves on by one cell per cycle while the chain advances, and
// the last cell registers the two product halves and then the sum before the output register
// takes it. The input stays stalled until the last product is taken. An output stall while a
// product waits at the output freezes the whole chain. Products come out in row-major order,
// shifted right by FRAC_BITS and saturated, with last set on the final entry. Kind 3 also
// writes every product back into the left operand; the write of an entry lands after all
// reads of its row are done, so later entries still see the old left operand.
module matrix_multiply_4x4 #(
    parameter int DIM       = mm4_pkg::DIM_DEF,
    parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEF,
    parameter int WORD_BITS = mm4_pkg::WORD_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        valid,
    output logic                        stall,
    input  logic [1:0]                  kind,
    input  logic [1:0]                  row,
    input  logic [1:0]                  col,
    input  logic signed [WORD_BITS-1:0] value,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [1:0]                  out_row,
    output logic [1:0]                  out_col,
    output logic signed [WORD_BITS-1:0] product,
    output logic                        last
);
    import mm4_pkg::*;

    localparam int IW = $clog2(DIM);
    localparam int AW = 2 * WORD_BITS + IW;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN
    } state_t;

    state_t state_reg;
    logic [IW-1:0] i_reg, j_reg;
    logic          keep_reg;

    logic                        out_valid_reg;
    logic [1:0]                  out_row_reg, out_col_reg;
    logic signed [WORD_BITS-1:0] product_reg;
    logic                        out_last_reg;

    tag_t                 tag_chain [DIM+1];
    tag_t                 res_tags  [DIM];
    logic signed [AW-1:0] sum_chain [DIM+1];
    tag_t                 tag_head;

    logic                        adv, in_acc, load_ok, wb_en, inj_last;
    logic signed [AW-1:0]        shifted;
    logic signed [WORD_BITS-1:0] sat_val;
    tag_t                        res;

    assign adv      = !out_valid_reg || !out_stall;
    assign stall    = (state_reg != ST_IDLE);
    assign in_acc   = valid && !stall;
    assign load_ok  = (32'(row) < DIM) && (32'(col) < DIM);
    assign inj_last = (i_reg == IW'(DIM - 1)) && (j_reg == IW'(DIM - 1));
    assign res      = res_tags[DIM-1];
    assign wb_en    = adv && res.valid && res.keep;

    always_comb
    begin
        tag_head       = '0;
        tag_head.valid = (state_reg == ST_ISSUE);
        tag_head.keep  = keep_reg;
        tag_head.last  = inj_last;
        tag_head.row   = IDX_BITS'(i_reg);
        tag_head.col   = IDX_BITS'(j_reg);
    end

    assign tag_chain[0] = tag_head;
    assign sum_chain[0] = '0;

    // arithmetic shift, then saturate unless the dropped high bits are pure sign
    always_comb
    begin
        shifted = sum_chain[DIM] >>> FRAC_BITS;
        if ((&shifted[AW-1:WORD_BITS-1]) || !(|shifted[AW-1:WORD_BITS-1]))
        begin
            sat_val = shifted[WORD_BITS-1:0];
        end
        else if (shifted[AW-1])
        begin
            sat_val = {1'b1, {(WORD_BITS-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(WORD_BITS-1){1'b1}}};
        end
    end

    for (genvar k = 0; k < DIM; k++)
    begin : g_cell
        logic                        lw_en, rw_en;
        logic [IW-1:0]               lw_addr;
        logic signed [WORD_BITS-1:0] lw_data;

        always_comb
        begin
            if (wb_en && (res.col[IW-1:0] == IW'(k)))
            begin
                lw_en   = 1'b1;
                lw_addr = res.row[IW-1:0];
                lw_data = sat_val;
            end
            else
            begin
                lw_en   = in_acc && load_ok && (kind_t'(kind) == KIND_LOAD_LEFT)
                          && (32'(col) == k);
                lw_addr = IW'(row);
                lw_data = value;
            end
            rw_en = in_acc && load_ok && (kind_t'(kind) == KIND_LOAD_RIGHT) && (32'(row) == k);
        end

        mm4_cell #(
            .DIM       (DIM),
            .WORD_BITS (WORD_BITS)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .adv     (adv),
            .tag_in  (tag_chain[k]),
            .tag_out (tag_chain[k+1]),
            .res_tag (res_tags[k]),
            .sum_in  (sum_chain[k]),
            .sum_out (sum_chain[k+1]),
            .lw_en   (lw_en),
            .lw_addr (lw_addr),
            .lw_data (lw_data),
            .rw_en   (rw_en),
            .rw_addr (IW'(col)),
            .rw_data (value)
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            i_reg         <= '0;
            j_reg         <= '0;
            keep_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            product_reg   <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                out_valid_reg <= res.valid;
                out_row_reg   <= res.row[1:0];
                out_col_reg   <= res.col[1:0];
                product_reg   <= sat_val;
                out_last_reg  <= res.last;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc && (kind_t'(kind) == KIND_MUL || kind_t'(kind) == KIND_MUL_KEEP))
                    begin
                        state_reg <= ST_ISSUE;
                        i_reg     <= '0;
                        j_reg     <= '0;
                        keep_reg  <= (kind_t'(kind) == KIND_MUL_KEEP);
                    end
                end
                ST_ISSUE:
                begin
                    if (adv)
                    begin
                        if (inj_last)
                        begin
                            state_reg <= ST_DRAIN;
                        end
                        else if (j_reg == IW'(DIM - 1))
                        begin
                            j_reg <= '0;
                            i_reg <= i_reg + IW'(1);
                        end
                        else
                        begin
                            j_reg <= j_reg + IW'(1);
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_valid_reg && !out_stall && out_last_reg)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_row   = out_row_reg;
    assign out_col   = out_col_reg;
    assign product   = product_reg;
    assign last      = out_last_reg;

`ifndef SYNTH
    // a product never waits at the output while the block is idle
    a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg != ST_IDLE))
        else $error("product pending while idle");

    // write-back into the left operand only happens during a multiply
    a_wb_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wb_en |-> (state_reg == ST_DRAIN || state_reg == ST_ISSUE))
        else $error("left write-back outside a multiply");

    // taking the final product returns the block to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && out_last_reg) |=> (state_reg == ST_IDLE))
        else $error("block still busy after final product");
`endif

endmodule

/* rtl/mm4_cell.sv */
// one multiply-add cell: holds a left column and a right row, adds its product to the chain sum
module mm4_cell #(
    parameter int DIM       = mm4_pkg::DIM_DEF,
    parameter int WORD_BITS = mm4_pkg::WORD_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          adv,
    input  mm4_pkg::tag_t                                 tag_in,
    output mm4_pkg::tag_t                                 tag_out,
    output mm4_pkg::tag_t                                 res_tag,
    input  logic signed [2*WORD_BITS+$clog2(DIM)-1:0]     sum_in,
    output logic signed [2*WORD_BITS+$clog2(DIM)-1:0]     sum_out,
    input  logic                                          lw_en,
    input  logic        [$clog2(DIM)-1:0]                 lw_addr,
    input  logic signed [WORD_BITS-1:0]                   lw_data,
    input  logic                                          rw_en,
    input  logic        [$clog2(DIM)-1:0]                 rw_addr,
    input  logic signed [WORD_BITS-1:0]                   rw_data
);
    import mm4_pkg::*;

    localparam int IW  = $clog2(DIM);
    localparam int AW  = 2 * WORD_BITS + IW;
    localparam int H   = WORD_BITS / 2;
    localparam int HB  = WORD_BITS - H;
    localparam int PLW = WORD_BITS + H + 1;
    localparam int PHW = WORD_BITS + HB;

    // left store column and right store row owned by this cell
    logic signed [WORD_BITS-1:0] lcol_reg [DIM];
    logic signed [WORD_BITS-1:0] rrow_reg [DIM];

    tag_t t0_reg, t1_reg, t2_reg;

    logic signed [WORD_BITS+H:0]    plo_reg, plo_next;
    logic signed [WORD_BITS+HB-1:0] phi_reg, phi_next;
    logic signed [AW-1:0]           sum_reg, sum_next;

    logic signed [WORD_BITS-1:0] a_op, b_op;
    logic signed [H:0]           b_lo;
    logic signed [HB-1:0]        b_hi;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < DIM; n++)
            begin
                lcol_reg[n] <= '0;
                rrow_reg[n] <= '0;
            end
        end
        else
        begin
            if (lw_en)
            begin
                lcol_reg[lw_addr] <= lw_data;
            end
            if (rw_en)
            begin
                rrow_reg[rw_addr] <= rw_data;
            end
        end
    end

    // the multiply is split on the right operand into a low and a high half
    always_comb
    begin
        a_op     = lcol_reg[t0_reg.row[IW-1:0]];
        b_op     = rrow_reg[t0_reg.col[IW-1:0]];
        b_lo     = $signed({1'b0, b_op[H-1:0]});
        b_hi     = $signed(b_op[WORD_BITS-1:H]);
        plo_next = PLW'(a_op) * PLW'(b_lo);
        phi_next = PHW'(a_op) * PHW'(b_hi);
        sum_next = sum_in + (AW'(phi_reg) <<< H) + AW'(plo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t0_reg <= '0;
            t1_reg <= '0;
            t2_reg <= '0;
        end
        else if (adv)
        begin
            t0_reg <= tag_in;
            t1_reg <= t0_reg;
            t2_reg <= t1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
            sum_reg <= sum_next;
        end
    end

    assign tag_out = t0_reg;
    assign res_tag = t2_reg;
    assign sum_out = sum_reg;

endmodule

/* sim/tb_matrix_multiply_4x4.sv */
// self-checking testbench for the 4x4 signed fixed-point matrix multiplier
module tb_matrix_multiply_4x4;
    timeunit 1ns;
    timeprecision 1ps;

    import mm4_pkg::*;

    localparam int N     = DIM_DEF;
    localparam int FRAC  = FRAC_BITS_DEF;
    localparam int WIDTH = WORD_BITS_DEF;

    localparam logic signed [WIDTH-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [WIDTH-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [WIDTH-1:0] ONE_Q    = 32'sh0001_0000;
    localparam logic signed [65:0]      SUM_MAX  = 66'sd2147483647;
    localparam logic signed [65:0]      SUM_MIN  = -66'sd2147483648;

    typedef struct {
        kind_t                   kind;
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [WIDTH-1:0] value;
        bit                      pin;     // product at (row, col) typed in below
        logic signed [WIDTH-1:0] pin_val;
    } op_t;

    typedef struct {
        logic [1:0]              row;
        logic [1:0]              col;
        logic signed [WIDTH-1:0] product;
        logic                    last;
    } entry_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    valid     = 1'b0;
    logic                    stall;
    kind_t                   kind      = KIND_LOAD_LEFT;
    logic [1:0]              row       = '0;
    logic [1:0]              col       = '0;
    logic signed [WIDTH-1:0] value     = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              out_row;
    logic [1:0]              out_col;
    logic signed [WIDTH-1:0] product;
    logic                    last;

    logic signed [WIDTH-1:0] left_m  [N*N];
    logic signed [WIDTH-1:0] right_m [N*N];
    entry_t                  product_q [$];
    entry_t                  head;
    int                      err_count      = 0;
    int                      send_idle_pct  = 0;
    int                      recv_stall_pct = 0;

    op_t directed_ops [22] = '{
        '{KIND_MUL,        2'd0, 2'd0, 32'sh0000_0000, 1'b1, 32'sh0000_0000}, // both operands clear
        '{KIND_MUL_KEEP,   2'd3, 2'd3, 32'sh1234_5678, 1'b1, 32'sh0000_0000},
        '{KIND_LOAD_LEFT,  2'd0, 2'd0, WORD_MAX,       1'b0, 32'sh0000_0000},
        '{KIND_LOAD_RIGHT, 2'd0, 2'd0, WORD_MAX,       1'b0, 32'sh0000_0000},
        '{KIND_MUL,        2'd0, 2'd0, 32'shDEAD_BEEF, 1'b1, WORD_MAX},       // clips high
        '{KIND_LOAD_RIGHT, 2'd0, 2'd0, WORD_MIN,       1'b0, 32'sh0000_0000},
        '{KIND_MUL,        2'd0, 2'd0, 32'sh0000_0000, 1'b1, WORD_MIN},       // clips low
        '{KIND_LOAD_LEFT,  2'd0, 2'd0, WORD_MIN,       1'b0, 32'sh0000_0000},
        '{KIND_MUL_KEEP,   2'd0, 2'd0, 32'shFFFF_FFFF, 1'b1, WORD_MAX},
        '{KIND_MUL,        2'd0, 2'd0, 32'sh0000_0000, 1'b1, WORD_MIN},       // sees kept left
        '{KIND_LOAD_LEFT,  2'd3, 2'd3, ONE_Q,          1'b0, 32'sh0000_0000},
        '{KIND_LOAD_RIGHT, 2'd3, 2'd3, ONE_Q,          1'b0, 32'sh0000_0000},
        '{KIND_MUL,        2'd3, 2'd3, 32'sh0000_0000, 1'b1, ONE_Q},
        '{KIND_LOAD_LEFT,  2'd1, 2'd2, 32'shFFFF_FFFF, 1'b0, 32'sh0000_0000},
        '{KIND_LOAD_RIGHT, 2'd2, 2'd1, 32'sh0000_0001, 1'b0, 32'sh0000_0000},
        '{KIND_MUL,        2'd1, 2'd1, 32'sh0000_0000, 1'b1, 32'shFFFF_FFFF}, // floors to -1
        '{KIND_LOAD_LEFT,  2'd2, 2'd1, 32'sh0000_8000, 1'b0, 32'sh0000_0000},
        '{KIND_LOAD_RIGHT, 2'd1, 2'd3, 32'sh7FFF_0000, 1'b0, 32'sh0000_0000},
        '{KIND_MUL,        2'd0, 2'd0, 32'sh0000_0000, 1'b0, 32'sh0000_0000},
        '{KIND_MUL_KEEP,   2'd2, 2'd1, 32'sh5555_AAAA, 1'b0, 32'sh0000_0000},
        '{KIND_LOAD_RIGHT, 2'd3, 2'd0, 32'sh8000_0001, 1'b0, 32'sh0000_0000},
        '{KIND_MUL,        2'd0, 2'd0, 32'sh0000_0000, 1'b0, 32'sh0000_0000}
    };

    matrix_multiply_4x4 u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (valid),
        .stall     (stall),
        .kind      (kind),
        .row       (row),
        .col       (col),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_row   (out_row),
        .out_col   (out_col),
        .product   (product),
        .last      (last)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // exact four-term dot product, floored shift, clipped to the word range
    function automatic logic signed [WIDTH-1:0] dot_sat(int i, int j);
        logic signed [65:0] acc;
        logic signed [65:0] a;
        logic signed [65:0] b;
        acc = '0;
        for (int k = 0; k < N; k++)
        begin
            a   = left_m[i*N + k];
            b   = right_m[k*N + j];
            acc = acc + a * b;
        end
        acc = acc >>> FRAC;
        if (acc > SUM_MAX)
            return WORD_MAX;
        if (acc < SUM_MIN)
            return WORD_MIN;
        return acc[WIDTH-1:0];
    endfunction

    task automatic apply_op(input op_t op);
        logic signed [WIDTH-1:0] prod [N*N];
        entry_t                  e;
        case (op.kind)
            KIND_LOAD_LEFT:  left_m[op.row*N + op.col]  = op.value;
            KIND_LOAD_RIGHT: right_m[op.row*N + op.col] = op.value;
            default:
            begin
                for (int i = 0; i < N; i++)
                    for (int j = 0; j < N; j++)
                        prod[i*N + j] = dot_sat(i, j);
                if (op.pin)
                    prod[op.row*N + op.col] = op.pin_val;
                for (int n = 0; n < N*N; n++)
                begin
                    e.row     = 2'(n / N);
                    e.col     = 2'(n % N);
                    e.product = prod[n];
                    e.last    = (n == N*N - 1);
                    product_q.push_back(e);
                end
                // every entry is formed from the old left operand before the write-back
                if (op.kind == KIND_MUL_KEEP)
                    left_m = prod;
            end
        endcase
    endtask

    task automatic send_op(input op_t op);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            valid <= 1'b0;
            @(posedge clk);
        end
        valid <= 1'b1;
        kind  <= op.kind;
        row   <= op.row;
        col   <= op.col;
        value <= op.value;
        do
            @(posedge clk);
        while (stall);
        apply_op(op);
    endtask

    function automatic logic signed [WIDTH-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return WIDTH'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
        if (sel < 8)
            return $urandom;
        case ($urandom_range(0, 5))
            0:       return WORD_MAX;
            1:       return WORD_MIN;
            2:       return '0;
            3:       return '1;
            4:       return ONE_Q;
            default: return -ONE_Q;
        endcase
    endfunction

    // mostly runs of loads that fill in entries, broken up by multiplies
    task automatic run_random(input int count);
        op_t op;
        int  r;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 39)
                op.kind = KIND_LOAD_LEFT;
            else if (r < 78)
                op.kind = KIND_LOAD_RIGHT;
            else if (r < 89)
                op.kind = KIND_MUL;
            else
                op.kind = KIND_MUL_KEEP;
            op.row     = 2'($urandom_range(0, 3));
            op.col     = 2'($urandom_range(0, 3));
            op.value   = pick_value();
            op.pin     = 1'b0;
            op.pin_val = '0;
            send_op(op);
        end
    endtask

    task automatic flag(input string msg);
        err_count++;
        if (err_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (product_q.size() == 0)
                flag($sformatf("unexpected transfer: row %0d col %0d product %h last %b",
                               out_row, out_col, product, last));
            else
            begin
                head = product_q.pop_front();
                if (out_row !== head.row || out_col !== head.col ||
                    product !== head.product || last !== head.last)
                    flag($sformatf("mismatch: expected %0d,%0d %h %b got %0d,%0d %h %b",
                                   head.row, head.col, head.product, head.last,
                                   out_row, out_col, product, last));
            end
        end
        out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial
    begin
        for (int n = 0; n < N*N; n++)
        begin
            left_m[n]  = '0;
            right_m[n] = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 18;
        recv_stall_pct = 86;
        foreach (directed_ops[i])
            send_op(directed_ops[i]);
        run_random(94);

        send_idle_pct  = 86;
        recv_stall_pct = 18;
        run_random(93);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(93);

        valid <= 1'b0;
        while (product_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0 && product_q.size() == 0)
            $display("tb_matrix_multiply_4x4 passed");
        else
            $display("tb_matrix_multiply_4x4 failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_matrix_multiply_4x4 failed");
        $finish;
    end

endmodule
